// File: rtl/jfbc5_pkg.sv
// ----------------------------------------------------------------------------
// jfbc5_pkg
// Shared types, constants and the CRC5 byte update for the job frame builder.
// ----------------------------------------------------------------------------
package jfbc5_pkg;

   // Frame constants
   localparam logic [7:0] FRAME_OPCODE  = 8'h01;
   localparam logic [4:0] CRC_INIT      = 5'h1F;
   localparam logic [4:0] CRC_POLY      = 5'h05;
   localparam logic [5:0] JOB_BYTES     = 6'd44;
   localparam logic [5:0] LAST_POSITION = 6'd43;
   localparam logic [1:0] LANE_LAST     = 2'd3;
   localparam int         GROUP_SLOTS   = 5;

   // Slot kinds: how the output stage treats a byte on its way out
   localparam logic [1:0] KIND_DATA  = 2'd0;  // payload byte, fed to the CRC
   localparam logic [1:0] KIND_FIRST = 2'd1;  // opcode byte, restarts the CRC
   localparam logic [1:0] KIND_CRC   = 2'd2;  // CRC byte, ends the frame

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
   } slot_type;

   // Group of results caused by one job byte
   typedef struct packed {
      logic [2:0]                   count;
      slot_type [GROUP_SLOTS-1:0]   slot;
   } group_type;

   // CRC5 over one byte, MSB first, polynomial x^5+x^2+1
   function automatic logic [4:0] crc5_feed(input logic [4:0] crc, input logic [7:0] data);
      logic [4:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = data[i] ^ c[4];
         c  = {c[3:0], 1'b0} ^ (fb ? CRC_POLY : 5'd0);
      end
      return c;
   endfunction

endpackage

// File: rtl/jfbc5_if.sv
// ----------------------------------------------------------------------------
// jfbc5 channel interfaces
// Valid/ready channels for job bytes in and frame bytes out.
// ----------------------------------------------------------------------------
interface jfbc5_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] job_byte;

   modport source (output valid, output job_byte, input ready);
   modport sink   (input valid, input job_byte, output ready);
endinterface

interface jfbc5_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_of_frame;

   modport source (output valid, output frame_byte, output last_of_frame, input ready);
   modport sink   (input valid, input frame_byte, input last_of_frame, output ready);
endinterface

// File: rtl/job_frame_builder_crc5_core.sv
// ----------------------------------------------------------------------------
// job_frame_builder_crc5_core
// Builds 47-byte job frames with a CRC5 trailer from 44 raw job bytes.
// ----------------------------------------------------------------------------
// Job bytes enter through a one-entry input register and may arrive every
// cycle while the output stage can take their groups. Each byte is turned in
// one pass into its group of frame bytes: the first byte of a job gives the
// opcode and the new job number, the last byte of each 4-byte word gives that
// word in reversed byte order, and the last job byte adds the CRC byte flagged
// by last_of_frame. The output stage sends one frame byte per cycle while the
// receiver is ready and computes the CRC5 as bytes leave, so a job of 44
// bytes yields 47 result transfers; 32 of the job bytes yield nothing. A 4- or
// 5-byte word burst holds new input behind the input register until its last
// byte is leaving.
// There are no configuration registers and no clearing pass after reset.
// ----------------------------------------------------------------------------
module job_frame_builder_crc5_core (
   input  logic        clock,
   input  logic        reset,
   jfbc5_req_if.sink   req_if,
   jfbc5_rsp_if.source rsp_if
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic [7:0]           job_ff, job_in;
   logic [5:0]           pos_ff, pos_in;
   logic [7:0]           wbuf_ff [3];
   logic                 can_load;
   logic                 load;
   logic                 req_xfer;
   logic [5:0]           pos_eff;
   logic [1:0]           lane;
   jfbc5_pkg::group_type group;

   // Input register handshake
   assign load          = in_valid_ff && can_load;
   assign req_if.ready  = !in_valid_ff || load;
   assign req_xfer      = req_if.valid && req_if.ready;
   assign in_valid_in   = req_xfer || (in_valid_ff && !load);

   // Frame position and lane of the buffered byte
   assign pos_eff = (pos_ff >= jfbc5_pkg::JOB_BYTES) ? 6'd0 : pos_ff;
   assign lane    = pos_eff[1:0];
   assign pos_in  = (pos_eff == jfbc5_pkg::LAST_POSITION) ? 6'd0 : pos_eff + 6'd1;
   assign job_in  = (pos_eff == 6'd0) ? job_ff + 8'd1 : job_ff;

   // Group of frame bytes for this job byte
   always_comb begin
      group = '0;
      for (int i = 0; i < jfbc5_pkg::GROUP_SLOTS; i++) begin
         group.slot[i].kind = jfbc5_pkg::KIND_DATA;
      end
      if (pos_eff == 6'd0) begin
         group.count        = 3'd2;
         group.slot[0].data = jfbc5_pkg::FRAME_OPCODE;
         group.slot[0].kind = jfbc5_pkg::KIND_FIRST;
         group.slot[1].data = job_in;
      end else if (lane == jfbc5_pkg::LANE_LAST) begin
         group.count        = 3'd4;
         group.slot[0].data = in_byte_ff;
         group.slot[1].data = wbuf_ff[2];
         group.slot[2].data = wbuf_ff[1];
         group.slot[3].data = wbuf_ff[0];
         if (pos_eff == jfbc5_pkg::LAST_POSITION) begin
            group.count        = 3'd5;
            group.slot[4].kind = jfbc5_pkg::KIND_CRC;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         job_ff      <= 8'd0;
         pos_ff      <= 6'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (load) begin
            job_ff <= job_in;
            pos_ff <= pos_in;
         end
      end
   end

   // Payload: input byte and word buffer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_if.job_byte;
      end
      if (load && (lane != jfbc5_pkg::LANE_LAST)) begin
         wbuf_ff[lane] <= in_byte_ff;
      end
   end

   jfbc5_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .group    (group),
      .can_load (can_load),
      .rsp      (rsp_if)
   );

endmodule

// File: rtl/jfbc5_emit.sv
// ----------------------------------------------------------------------------
// jfbc5_emit
// Output stage: holds one group of up to five frame bytes, sends them one per
// transfer and runs the frame CRC over the bytes as they leave.
// ----------------------------------------------------------------------------
module jfbc5_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  jfbc5_pkg::group_type group,
   output logic                 can_load,
   jfbc5_rsp_if.source          rsp
);

   logic [2:0]                                 cnt_ff, cnt_in;
   jfbc5_pkg::slot_type [jfbc5_pkg::GROUP_SLOTS-1:0] slot_ff, slot_in;
   logic [4:0]                                 crc_ff, crc_in;
   logic                                       xfer;

   // Head slot drives the channel
   assign xfer          = (cnt_ff != 3'd0) && rsp.ready;
   assign can_load      = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp.ready);
   assign rsp.valid     = (cnt_ff != 3'd0);
   assign rsp.last_of_frame = (slot_ff[0].kind == jfbc5_pkg::KIND_CRC);
   assign rsp.frame_byte = rsp.last_of_frame ? {3'b000, crc_ff} : slot_ff[0].data;

   // Group load or shift toward the head
   always_comb begin
      cnt_in  = cnt_ff;
      slot_in = slot_ff;
      if (load) begin
         cnt_in  = group.count;
         slot_in = group.slot;
      end else if (xfer) begin
         cnt_in = cnt_ff - 3'd1;
         for (int i = 0; i < jfbc5_pkg::GROUP_SLOTS - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
      end
   end

   // CRC update on each outgoing opcode or payload byte
   always_comb begin
      crc_in = crc_ff;
      if (xfer) begin
         unique case (slot_ff[0].kind)
            jfbc5_pkg::KIND_FIRST: crc_in = jfbc5_pkg::crc5_feed(jfbc5_pkg::CRC_INIT,
                                                                 slot_ff[0].data);
            jfbc5_pkg::KIND_CRC:   crc_in = crc_ff;
            default:               crc_in = jfbc5_pkg::crc5_feed(crc_ff, slot_ff[0].data);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         crc_ff <= jfbc5_pkg::CRC_INIT;
      end else begin
         cnt_ff <= cnt_in;
         crc_ff <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// File: tb/job_frame_builder_crc5_core_tb.sv
// ----------------------------------------------------------------------------
// job_frame_builder_crc5_core_tb
// Self-checking bench for the CRC5 job frame builder. A table of directed job
// bytes opens the first frame. It covers field extremes and single-bit
// patterns and pins the frame start and first three words by hand. Random
// jobs then run through four handshake phases: no idling, sender gaps,
// receiver stalls, and both together. Every unpinned frame byte is checked in
// order against a bit-accurate predictor of frame layout and CRC5 trailer.
// ----------------------------------------------------------------------------
module job_frame_builder_crc5_core_tb;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 8;
   localparam int DIRECTED_COUNT = 24;
   localparam int PHASE_ITEMS    = 93;    // 24 + 4 * 93 = 9 whole frames
   localparam int DRAIN_CYCLES   = 16;
   localparam int LIMIT_CYCLES   = 200000;

   // One expected frame byte
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_of_frame;
   } frame_out_type;

   // Directed row: job byte plus up to four frame bytes typed in by hand,
   // listed first-out first as {b0, b1, b2, b3}
   typedef struct packed {
      logic [7:0]      job_byte;
      logic [2:0]      pinned_count;
      logic [3:0][7:0] pinned;
   } job_row_type;

   localparam job_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // first byte after reset: opcode, then job number 1
      '{8'h00, 3'd2, {8'h01, 8'h01, 8'h00, 8'h00}},
      '{8'hFF, 3'd0, 32'h0},
      '{8'h80, 3'd0, 32'h0},
      '{8'h7F, 3'd4, {8'h7F, 8'h80, 8'hFF, 8'h00}},
      // all ones word
      '{8'hFF, 3'd0, 32'h0},
      '{8'hFF, 3'd0, 32'h0},
      '{8'hFF, 3'd0, 32'h0},
      '{8'hFF, 3'd4, {8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      // all zeros word
      '{8'h00, 3'd0, 32'h0},
      '{8'h00, 3'd0, 32'h0},
      '{8'h00, 3'd0, 32'h0},
      '{8'h00, 3'd4, {8'h00, 8'h00, 8'h00, 8'h00}},
      // walking ones
      '{8'h01, 3'd0, 32'h0},
      '{8'h02, 3'd0, 32'h0},
      '{8'h04, 3'd0, 32'h0},
      '{8'h08, 3'd0, 32'h0},
      '{8'h10, 3'd0, 32'h0},
      '{8'h20, 3'd0, 32'h0},
      '{8'h40, 3'd0, 32'h0},
      '{8'h80, 3'd0, 32'h0},
      // alternating patterns
      '{8'hAA, 3'd0, 32'h0},
      '{8'h55, 3'd0, 32'h0},
      '{8'hA5, 3'd0, 32'h0},
      '{8'h5A, 3'd0, 32'h0}
   };

   logic clock;
   logic reset;

   jfbc5_req_if req_ch ();
   jfbc5_rsp_if rsp_ch ();

   job_frame_builder_crc5_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Predictor state
   logic [7:0] pred_job_number = 8'd0;
   logic [5:0] pred_position   = 6'd0;
   logic [7:0] pred_word [3]   = '{8'd0, 8'd0, 8'd0};
   logic [4:0] pred_crc        = jfbc5_pkg::CRC_INIT;

   frame_out_type pending_frame_bytes [$];
   int            mismatch_count = 0;
   int            send_idle_pct  = 0;
   int            stall_pct      = 0;

   // CRC5 step over one byte, MSB first
   function automatic logic [4:0] crc5_next(input logic [4:0] crc, input logic [7:0] d);
      logic [4:0] r;
      logic       fb;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         fb = d[7-i] ^ r[4];
         r  = {r[3:0], 1'b0};
         if (fb)
            r = r ^ jfbc5_pkg::CRC_POLY;
      end
      return r;
   endfunction

   // Payload byte: folded into the CRC, queued when wanted
   task automatic queue_payload(input logic [7:0] d, input bit keep);
      frame_out_type item;
      pred_crc = crc5_next(pred_crc, d);
      item.frame_byte    = d;
      item.last_of_frame = 1'b0;
      if (keep)
         pending_frame_bytes.push_back(item);
   endtask

   // Advance the frame model by one job byte
   task automatic predict_job_byte(input logic [7:0] b, input bit keep);
      logic [5:0]    pos;
      frame_out_type item;
      pos = pred_position;
      // unreachable position folds back to a frame start
      if (pos >= jfbc5_pkg::JOB_BYTES)
         pos = 6'd0;

      // frame start: new job number, CRC restart
      if (pos == 6'd0) begin
         pred_job_number = pred_job_number + 8'd1;
         pred_crc        = jfbc5_pkg::CRC_INIT;
         queue_payload(jfbc5_pkg::FRAME_OPCODE, keep);
         queue_payload(pred_job_number, keep);
      end

      // word collection, reversed on the last lane
      if (pos[1:0] != jfbc5_pkg::LANE_LAST) begin
         pred_word[pos[1:0]] = b;
      end else begin
         queue_payload(b, keep);
         queue_payload(pred_word[2], keep);
         queue_payload(pred_word[1], keep);
         queue_payload(pred_word[0], keep);
      end

      // trailer
      if (pos == jfbc5_pkg::LAST_POSITION) begin
         item.frame_byte    = {3'b000, pred_crc};
         item.last_of_frame = 1'b1;
         if (keep)
            pending_frame_bytes.push_back(item);
         pred_position = 6'd0;
      end else begin
         pred_position = pos + 6'd1;
      end
   endtask

   task automatic flag_mismatch(input string what, input frame_out_type want,
                                input frame_out_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch (%s): expected byte %02h last %0d, got byte %02h last %0d",
                  what, want.frame_byte, want.last_of_frame,
                  got.frame_byte, got.last_of_frame);
   endtask

   // One job byte transfer, with random gaps ahead of it
   task automatic send_job_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.job_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Run limit
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side: random ready, in-order check of each transfer
   initial begin
      frame_out_type got;
      frame_out_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.frame_byte    = rsp_ch.frame_byte;
            got.last_of_frame = rsp_ch.last_of_frame;
            if (pending_frame_bytes.size() == 0) begin
               want = '0;
               flag_mismatch("no byte pending", want, got);
            end else begin
               want = pending_frame_bytes.pop_front();
               if (got.frame_byte !== want.frame_byte)
                  flag_mismatch("frame_byte", want, got);
               if (got.last_of_frame !== want.last_of_frame)
                  flag_mismatch("last_of_frame", want, got);
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Stimulus
   initial begin
      logic [7:0]    b;
      job_row_type   row;
      frame_out_type item;

      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.job_byte <= 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         row = DIRECTED_ROWS[r];
         send_job_byte(row.job_byte);
         if (row.pinned_count != 3'd0) begin
            predict_job_byte(row.job_byte, 1'b0);
            for (int i = 0; i < row.pinned_count; i++) begin
               item.frame_byte    = row.pinned[3-i];
               item.last_of_frame = 1'b0;
               pending_frame_bytes.push_back(item);
            end
         end else begin
            predict_job_byte(row.job_byte, 1'b1);
         end
      end

      // random jobs across the handshake phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 59; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 59; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase

         // before the stall phase, hold off until every predicted frame byte is out
         if (phase == 2) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending_frame_bytes.size() != 0) @(posedge clock);
         end

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 15))
               0:       b = 8'h00;
               1:       b = 8'hFF;
               default: b = 8'($urandom_range(0, 255));
            endcase
            send_job_byte(b);
            predict_job_byte(b, 1'b1);
         end
      end
      req_ch.valid <= 1'b0;

      // drain
      while (pending_frame_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_frame_bytes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: job_frame_builder_crc5_core.f
rtl/jfbc5_pkg.sv
rtl/jfbc5_if.sv
rtl/jfbc5_emit.sv
rtl/job_frame_builder_crc5_core.sv
tb/job_frame_builder_crc5_core_tb.sv
